// ===== hw/rtl/sorted_priority_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Concurrent assertion wrappers clocked on clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// check prop at every clock edge outside reset
`define SPQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that cond never holds
`define SPQ_ASSERT_NEVER(label, cond, msg) \
   `SPQ_ASSERT(label, !(cond), msg)

`endif

// ===== hw/rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, codes and the link and command types shared by the queue cells.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

   localparam int DEPTH    = 16;
   localparam int KEY_BITS = 16;
   localparam int TAG_BITS = 8;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_DUP   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_IDLE   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
   } cmd_type;

   typedef struct packed {
      logic                occ;
      logic                after;
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
   } link_type;

endpackage

`default_nettype wire

// ===== hw/rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; on insert keeps, takes the new entry or takes its lower
// neighbor's entry; on remove takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
   input  wire logic              clock,
   input  wire spq_pkg::cmd_type  cmd,
   input  wire logic              occ,
   input  wire spq_pkg::link_type prev_link,
   input  wire spq_pkg::link_type next_link,
   output spq_pkg::link_type      link,
   output logic                   tail_match
);
   import spq_pkg::*;

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic                after;

   assign after = !occ || (key_ff > cmd.key);

   assign link.occ   = occ;
   assign link.after = after;
   assign link.key   = key_ff;
   assign link.tag   = tag_ff;

   // tail entry whose key is not greater than the new key and whose tag equals the new tag
   assign tail_match = occ && !next_link.occ && !after && (tag_ff == cmd.tag);

   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      unique case (cmd.op)
         OP_INSERT: begin
            if (after && prev_link.after) begin
               key_in = prev_link.key;
               tag_in = prev_link.tag;
            end else if (after) begin
               key_in = cmd.key;
               tag_in = cmd.tag;
            end
         end
         OP_REMOVE: begin
            key_in = next_link.key;
            tag_in = next_link.tag;
         end
         OP_IDLE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded min-first queue held as a row of cells in ascending key order.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  request   start, busy            req_action, req_key, req_tag
//  response  rsp_valid (strobe)     rsp_status, rsp_out_key, rsp_out_tag,
//                                   rsp_occupancy
//
//  One transaction per cycle: every cell compares against the new key in
//  parallel and shifts in the same cycle; busy stays low.
//  The response strobes in the cycle after start, for exactly one cycle.
//  Synchronous reset empties the queue; entries beyond the fill count are
//  never read. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_action,
   input  wire logic [spq_pkg::KEY_BITS-1:0]  req_key,
   input  wire logic [spq_pkg::TAG_BITS-1:0]  req_tag,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [spq_pkg::KEY_BITS-1:0]       rsp_out_key,
   output logic [spq_pkg::TAG_BITS-1:0]       rsp_out_tag,
   output logic [spq_pkg::CNT_BITS-1:0]       rsp_occupancy
);
   import spq_pkg::*;

   cmd_type             cmd;
   link_type            links [DEPTH];
   link_type            prev_links [DEPTH];
   link_type            next_links [DEPTH];
   logic [DEPTH-1:0]    occ;
   logic [DEPTH-1:0]    tail_hits;
   logic                dup;
   logic                full;
   logic                empty;
   status_type          status;
   logic                rsp_is_empty;
   logic                rsp_is_full;

   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                valid_ff, valid_in;
   status_type          status_ff;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;

   assign busy  = 1'b0;
   assign full  = (count_ff == CNT_BITS'(DEPTH));
   assign empty = (count_ff == '0);
   assign dup   = |tail_hits;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         assign occ[i] = (count_ff > CNT_BITS'(i));
         if (i == 0) begin : g_head
            assign prev_links[i] = '0;
         end else begin : g_body
            assign prev_links[i] = links[i-1];
         end
         if (i == DEPTH - 1) begin : g_last
            assign next_links[i] = '0;
         end else begin : g_inner
            assign next_links[i] = links[i+1];
         end
         spq_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .occ        (occ[i]),
            .prev_link  (prev_links[i]),
            .next_link  (next_links[i]),
            .link       (links[i]),
            .tail_match (tail_hits[i])
         );
      end
   endgenerate

   // decode the transaction
   always_comb begin
      cmd.key  = req_key;
      cmd.tag  = req_tag;
      cmd.op   = OP_IDLE;
      status   = ST_OK;
      count_in = count_ff;
      key_in   = '0;
      tag_in   = '0;
      if (start) begin
         priority if (req_action == ACT_REMOVE) begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               cmd.op   = OP_REMOVE;
               key_in   = links[0].key;
               tag_in   = links[0].tag;
               count_in = count_ff - CNT_BITS'(1);
            end
         end else if (full) begin
            status = ST_FULL;
         end else if (dup) begin
            status = ST_DUP;
         end else begin
            cmd.op   = OP_INSERT;
            count_in = count_ff + CNT_BITS'(1);
         end
      end
   end

   assign valid_in = start;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status;
      key_ff    <= key_in;
      tag_ff    <= tag_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_out_key   = key_ff;
   assign rsp_out_tag   = tag_ff;
   assign rsp_occupancy = count_ff;

   assign rsp_is_empty = rsp_valid && (rsp_status == ST_EMPTY);
   assign rsp_is_full  = rsp_valid && (rsp_status == ST_FULL);

   `SPQ_ASSERT(a_rsp_follows_start, start |=> rsp_valid, "response missing after start")
   `SPQ_ASSERT(a_head_sorted, occ[1] |-> (links[0].key <= links[1].key), "head out of order")
   `SPQ_ASSERT_NEVER(a_empty_count, rsp_is_empty && !empty, "empty status with entries held")
   `SPQ_ASSERT_NEVER(a_full_count, rsp_is_full && !full, "full status below depth")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Feeds insert and remove commands through the start/busy port with random
// gaps, predicts every response from a private copy of the sorted store and
// compares each strobed response field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module tb_top;

   import spq_pkg::*;

   localparam int STALL_LIMIT  = 1000;
   localparam int RANDOM_ITEMS = 1000;
   localparam int CALM_FIRST   = 400;
   localparam int CALM_LAST    = 650;

   typedef enum int {
      LEAN_FILL,
      LEAN_DRAIN,
      LEAN_EVEN
   } lean_type;

   typedef struct packed {
      logic                action;
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
   } queue_request_type;

   typedef struct packed {
      status_type          status;
      logic [KEY_BITS-1:0] out_key;
      logic [TAG_BITS-1:0] out_tag;
      logic [CNT_BITS-1:0] occupancy;
   } queue_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_action = ACT_INSERT;
   logic [KEY_BITS-1:0] req_key = '0;
   logic [TAG_BITS-1:0] req_tag = '0;
   logic                rsp_valid;
   logic [1:0]          rsp_status;
   logic [KEY_BITS-1:0] rsp_out_key;
   logic [TAG_BITS-1:0] rsp_out_tag;
   logic [CNT_BITS-1:0] rsp_occupancy;

   queue_request_type pending_requests[$];
   queue_result_type  predicted_results[$];

   logic [KEY_BITS-1:0] held_key[DEPTH];
   logic [TAG_BITS-1:0] held_tag[DEPTH];
   int                  held_count = 0;

   logic req_taken = 1'b0;
   int   sent_count = 0;
   int   stall_cycles = 0;
   int   error_count = 0;

   sorted_priority_queue u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_action    (req_action),
      .req_key       (req_key),
      .req_tag       (req_tag),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_out_key   (rsp_out_key),
      .rsp_out_tag   (rsp_out_tag),
      .rsp_occupancy (rsp_occupancy)
   );

   always #5 clock = ~clock;

   function automatic queue_result_type next_queue_result(input logic act,
                                                          input logic [KEY_BITS-1:0] k,
                                                          input logic [TAG_BITS-1:0] t);
      queue_result_type r;
      int               pos;
      int               i;
      r.status  = ST_OK;
      r.out_key = '0;
      r.out_tag = '0;
      if (act == ACT_REMOVE) begin
         if (held_count == 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.out_key = held_key[0];
            r.out_tag = held_tag[0];
            for (i = 1; i < held_count; i++) begin
               held_key[i-1] = held_key[i];
               held_tag[i-1] = held_tag[i];
            end
            held_count--;
         end
      end else if (held_count >= DEPTH) begin
         r.status = ST_FULL;
      end else begin
         pos = 0;
         while (pos < held_count && held_key[pos] <= k) pos++;
         if (pos == held_count && held_count > 0 && held_tag[held_count-1] == t) begin
            r.status = ST_DUP;
         end else begin
            for (i = held_count; i > pos; i--) begin
               held_key[i] = held_key[i-1];
               held_tag[i] = held_tag[i-1];
            end
            held_key[pos] = k;
            held_tag[pos] = t;
            held_count++;
         end
      end
      r.occupancy = held_count[CNT_BITS-1:0];
      return r;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   task automatic add_request(input logic act, input logic [KEY_BITS-1:0] k,
                              input logic [TAG_BITS-1:0] t);
      queue_request_type q;
      q.action = act;
      q.key    = k;
      q.tag    = t;
      pending_requests.push_back(q);
   endtask

   // driver: hold the transaction until taken, then advance or idle
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (pending_requests.size() != 0 &&
             !((sent_count < CALM_FIRST || sent_count >= CALM_LAST) &&
               $urandom_range(99) < 19)) begin
            req_action <= pending_requests[0].action;
            req_key    <= pending_requests[0].key;
            req_tag    <= pending_requests[0].tag;
            start      <= 1'b1;
            pending_requests.pop_front();
            sent_count++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check strobed responses, then predict the accepted transaction
   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         req_taken    <= 1'b0;
         stall_cycles <= 0;
      end else begin
         req_taken <= start && !busy;
         if (rsp_valid) begin
            if (predicted_results.size() == 0) begin
               flag_mismatch("response with no transaction outstanding");
            end else begin
               want = predicted_results.pop_front();
               if (rsp_status !== want.status)
                  flag_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
               if (rsp_out_key !== want.out_key)
                  flag_mismatch($sformatf("out_key %h, want %h", rsp_out_key, want.out_key));
               if (rsp_out_tag !== want.out_tag)
                  flag_mismatch($sformatf("out_tag %h, want %h", rsp_out_tag, want.out_tag));
               if (rsp_occupancy !== want.occupancy)
                  flag_mismatch($sformatf("occupancy %0d, want %0d", rsp_occupancy,
                                          want.occupancy));
            end
         end
         if (start && !busy)
            predicted_results.push_back(next_queue_result(req_action, req_key, req_tag));
         if ((start && !busy) || rsp_valid) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      lean_type  lean;
      int        burst;
      int        random_count;
      int        cut;
      int        sel;
      logic [KEY_BITS-1:0] k;
      logic [TAG_BITS-1:0] t;

      add_request(ACT_REMOVE, 16'hFFFF, 8'hFF);
      add_request(ACT_INSERT, 16'h8000, 8'h55);
      add_request(ACT_INSERT, 16'h8000, 8'h55);
      add_request(ACT_INSERT, 16'h0000, 8'h55);
      add_request(ACT_INSERT, 16'h8000, 8'hAA);
      add_request(ACT_INSERT, 16'hFFFF, 8'hFF);
      for (int j = 0; j < 12; j++)
         add_request(ACT_INSERT, 16'(j * 16'h1000), 8'(j * 8'h17));
      add_request(ACT_INSERT, 16'hFFFF, 8'hFF);
      add_request(ACT_REMOVE, 16'h0000, 8'h00);
      add_request(ACT_REMOVE, 16'h5A5A, 8'hA5);

      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         lean  = lean_type'($urandom_range(2));
         burst = $urandom_range(40, 5);
         cut   = (lean == LEAN_FILL) ? 15 : (lean == LEAN_DRAIN) ? 85 : 50;
         repeat (burst) begin
            if ($urandom_range(99) < cut) begin
               add_request(ACT_REMOVE, KEY_BITS'($urandom), TAG_BITS'($urandom));
            end else begin
               sel = $urandom_range(9);
               if (sel < 4)       k = KEY_BITS'($urandom_range(7));
               else if (sel == 4) k = '0;
               else if (sel == 5) k = '1;
               else               k = KEY_BITS'($urandom);
               t = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
               add_request(ACT_INSERT, k, t);
            end
            random_count++;
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || start || predicted_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);

      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
